### rtl/decorated_path_crc32_assert.svh
// assertion macros for the rtl file that checks itself
`ifndef DECORATED_PATH_CRC32_ASSERT_SVH
`define DECORATED_PATH_CRC32_ASSERT_SVH

// checked outside reset only
`define DPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define DPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// shared constants, types and the crc-32 byte update for the path hash
// ----------------------------------------------------------------------------
`default_nettype none

package dpc_pkg;

  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
  localparam logic [31:0] LOW_BYTE_MASK = 32'h000000FF;
  localparam logic [7:0]  CH_NUL        = 8'h00;
  localparam logic [7:0]  CH_HASH       = 8'h23;
  localparam logic [7:0]  CH_SLASH      = 8'h2F;
  localparam logic [7:0]  CH_BSLASH     = 8'h5C;
  localparam logic [1:0]  LA_EMPTY      = 2'd0;
  localparam logic [1:0]  LA_FULL       = 2'd2;

  typedef struct packed {
    logic [31:0] crc;
    logic        esc;
    logic        term;
  } hash_state_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        present;
    logic        first;
    logic        last;
    logic [31:0] seed;
  } item_t;

  // reflected crc-32 update by one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] c);
    logic [31:0] v;
    v = (crc & LOW_BYTE_MASK) ^ {24'd0, c};
    for (int k = 0; k < 8; k++) begin
      v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
    end
    return (crc >> 8) ^ v;
  endfunction

endpackage

`default_nettype wire

### rtl/dpc_hash_step.sv
// ----------------------------------------------------------------------------
// dpc_hash_step
// applies one path byte to the hash state: end mark, escape, slash skip, reload
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_hash_step (
  input  wire logic                 en,
  input  wire logic [7:0]           data,
  input  wire logic                 reload,
  input  wire logic [31:0]          inv_seed,
  input  wire dpc_pkg::hash_state_t st_in,
  output dpc_pkg::hash_state_t      st_out
);

  always_comb begin
    st_out = st_in;
    if (en && !st_in.term) begin
      if (data == dpc_pkg::CH_NUL) begin
        st_out.term = 1'b1;
      end else if (data == dpc_pkg::CH_BSLASH && !st_in.esc) begin
        st_out.esc = 1'b1;
      end else if (data == dpc_pkg::CH_SLASH && !st_in.esc) begin
        st_out = st_in;
      end else begin
        // only a '#' with two more '#' behind it restarts from the seed
        st_out.crc = dpc_pkg::crc_byte(
          (reload && data == dpc_pkg::CH_HASH) ? inv_seed : st_in.crc, data);
        st_out.esc = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/dpc_core.sv
// ----------------------------------------------------------------------------
// dpc_core
// hash state, two-byte lookahead and the chained byte updates for one beat
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire dpc_pkg::item_t item,
  output logic [31:0]         hash
);

  dpc_pkg::hash_state_t state;
  logic [31:0]          inv_seed;
  logic [7:0]           la_old;
  logic [7:0]           la_new;
  logic [1:0]           la_count;

  dpc_pkg::hash_state_t st0, st1, st2, st3;
  logic [31:0]          inv0;
  logic [31:0]          seed_eff;
  logic [1:0]           cnt0;
  logic [1:0]           cnt1;
  logic [7:0]           old1, new1;
  logic                 en1, en2, en3;
  logic                 rl1;
  logic [1:0]           la_count_next;

  always_comb begin
    st0  = state;
    inv0 = inv_seed;
    cnt0 = la_count;
    seed_eff = item.seed;
    if (item.first) begin
      if (item.present && item.data == dpc_pkg::CH_SLASH) begin
        seed_eff = 32'd0;
      end
      inv0      = ~seed_eff;
      st0.crc   = ~seed_eff;
      st0.esc   = 1'b0;
      st0.term  = 1'b0;
      cnt0      = dpc_pkg::LA_EMPTY;
    end

    // a full lookahead pushes out its oldest byte
    en1  = item.present && cnt0 == dpc_pkg::LA_FULL;
    rl1  = la_new == dpc_pkg::CH_HASH && item.data == dpc_pkg::CH_HASH;
    old1 = la_old;
    new1 = la_new;
    cnt1 = cnt0;
    if (item.present) begin
      if (cnt0 == dpc_pkg::LA_FULL) begin
        old1 = la_new;
        new1 = item.data;
      end else begin
        if (cnt0[0]) begin
          new1 = item.data;
        end else begin
          old1 = item.data;
        end
        cnt1 = cnt0 + 2'd1;
      end
    end

    // end of string drains what is queued
    en2 = item.last && cnt1 != dpc_pkg::LA_EMPTY;
    en3 = item.last && cnt1 == dpc_pkg::LA_FULL;
    la_count_next = item.last ? dpc_pkg::LA_EMPTY : cnt1;
  end

  dpc_hash_step u_step1 (
    .en(en1), .data(la_old), .reload(rl1), .inv_seed(inv0), .st_in(st0), .st_out(st1)
  );

  // bytes past the end never count as '#', so the drain never reloads
  dpc_hash_step u_step2 (
    .en(en2), .data(old1), .reload(1'b0), .inv_seed(inv0), .st_in(st1), .st_out(st2)
  );

  dpc_hash_step u_step3 (
    .en(en3), .data(new1), .reload(1'b0), .inv_seed(inv0), .st_in(st2), .st_out(st3)
  );

  assign hash = ~st3.crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= '0;
      inv_seed <= 32'd0;
      la_old   <= 8'd0;
      la_new   <= 8'd0;
      la_count <= dpc_pkg::LA_EMPTY;
    end else if (fire) begin
      state    <= st3;
      inv_seed <= inv0;
      la_old   <= old1;
      la_new   <= new1;
      la_count <= la_count_next;
    end
  end

endmodule

`default_nettype wire

### rtl/decorated_path_crc32.sv
// ----------------------------------------------------------------------------
// decorated_path_crc32
// crc-32 of a decorated path string, one byte per beat, hash on the last beat
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   input   | in_valid / in_ready  | data_byte, byte_present, first_byte,
//           |                      | last_byte, start_seed
//   output  | out_valid / out_ready| path_hash
//
// one beat per cycle unless a waiting result stalls a last beat; a last beat's hash lands in path_hash.
// the per-beat path is the input register, then up to three chained byte
// updates in dpc_core, then the hash state and result registers.
// reset clears the hash state, lookahead and both valid flags; no clearing pass.
// a held result stalls only a last beat in the input register; other beats
// keep flowing while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module decorated_path_crc32 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        first_byte,
  input  wire logic        last_byte,
  input  wire logic [31:0] start_seed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      path_hash
);

  dpc_pkg::item_t in_item;
  logic           in_full;
  logic           advance;
  logic [31:0]    core_hash;

  assign advance  = in_full && (!in_item.last || !out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item.data    <= data_byte;
      in_item.present <= byte_present;
      in_item.first   <= first_byte;
      in_item.last    <= last_byte;
      in_item.seed    <= start_seed;
    end
  end

  dpc_core u_core (
    .clk(clk), .rst(rst), .fire(advance), .item(in_item), .hash(core_hash)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_item.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_item.last) begin
      path_hash <= core_hash;
    end
  end

`include "decorated_path_crc32_assert.svh"

  // a last beat never overwrites a result still waiting
  `DPC_ASSERT(a_no_overwrite, (advance && in_item.last) |-> (!out_valid || out_ready), "result overwritten")
  // a fresh result only follows a last beat leaving the input register
  `DPC_ASSERT(a_result_src, $rose(out_valid) |-> $past(advance && in_item.last), "result without last beat")
  // back-pressure only with a held beat
  `DPC_ASSERT(a_ready_low, !in_ready |-> (in_full && in_item.last && out_valid), "spurious stall")
  `DPC_ASSERT_ALWAYS(a_reset_idle, (!rst && $past(rst)) |-> (!out_valid && !in_full), "not idle after reset")

endmodule

`default_nettype wire
